// File: rtl/kcl_pkg.sv
// shared types and constants of the keyed circular list engine
`default_nettype none

package kcl_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the channels
  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  // operation selector
  typedef enum logic [FUNC_W-1:0] {
    F_PUSH_FRONT = 3'd0,
    F_PUSH_BACK  = 3'd1,
    F_INS_AFTER  = 3'd2,
    F_POP_FRONT  = 3'd3,
    F_POP_BACK   = 3'd4,
    F_DEL_AFTER  = 3'd5,
    F_DUMP       = 3'd6
  } func_t;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // what a cell loads on the next edge
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_HEAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      cmp_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/kcl_in_if.sv
// operation word channel
`default_nettype none

interface kcl_in_if import kcl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [FUNC_W-1:0] func;
  logic signed [WORD_W-1:0] data_in;
  logic signed [WORD_W-1:0] search_key;

  modport source (output valid, func, data_in, search_key, input ready);
  modport sink   (input valid, func, data_in, search_key, output ready);
endinterface

`default_nettype wire

// File: rtl/kcl_out_if.sv
// result word channel
`default_nettype none

interface kcl_out_if import kcl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic signed [WORD_W-1:0]   data_out;
  logic        [ECOUNT_W-1:0] entry_count;
  logic                       last_out;

  modport source (output valid, status, data_out, entry_count, last_out, input ready);
  modport sink   (input valid, status, data_out, entry_count, last_out, output ready);
endinterface

`default_nettype wire

// File: rtl/keyed_circular_list_engine_core.sv
// top level of the keyed circular list engine: control and row of cells
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------
//  in_if    | in  | valid / ready    | func, data_in, search_key
//  out_if   | out | valid / ready    | status, data_out, entry_count, last_out
//
// every operation has an accept edge, where all cells compare
// their word with the key at once, and an execute step, where the cells shift,
// load or hold and the result word is registered
// a dump emits one word per cycle from cell 0 while the result is not stalled,
// as the row rotates by one per word, and leaves the list as it was
// reset (rst_n low, synchronous) empties the list; cell contents keep garbage
// a stalled result holds the block in place; in_if.ready is high only when idle
`default_nettype none

module keyed_circular_list_engine_core import kcl_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kcl_in_if.sink     in_if,
  kcl_out_if.source  out_if
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  state_t                state_r;
  func_t                 func_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r;

  // result register
  logic                       out_valid_r;
  status_t                    status_r, status_nxt;
  logic signed [WORD_W-1:0]   data_r, data_nxt;
  logic        [ECOUNT_W-1:0] ecount_r;
  logic                       last_r, last_nxt;

  // row of cells
  logic [DATA_WIDTH-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   vld, tail, at_cnt;
  cell_cmd_t             cmd [CAPACITY];

  logic [DATA_WIDTH-1:0] key_w;
  logic                  in_fire, out_free, step, done;
  logic [CAPACITY-1:0]   hit, first, upto;
  logic                  found, tail_hit, full, empty;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign step        = (state_r != S_IDLE) && out_free;

  // sign-extend or cut the key to the stored width
  assign key_w = DATA_WIDTH'(in_if.search_key);

  // position masks from the count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_pos
    assign vld[i]    = cnt_r > CW'(i);
    assign tail[i]   = cnt_r == CW'(i + 1);
    assign at_cnt[i] = cnt_r == CW'(i);
  end

  // first matching valid cell as a one-hot, and everything up to it
  assign hit      = match & vld;
  assign first    = hit & (~hit + 1'b1);
  assign upto     = first | (first - 1'b1);
  assign found    = |hit;
  assign tail_hit = |(first & tail);
  assign full     = cnt_r == CW'(CAPACITY);
  assign empty    = cnt_r == '0;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i] = CMD_HOLD;
    end
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    data_nxt   = '0;
    last_nxt   = 1'b1;
    done       = 1'b1;

    case (func_r)
      F_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          // everyone moves one place toward the tail
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i] = (i == 0) ? CMD_LOAD : CMD_LEFT;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      F_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (at_cnt[i]) cmd[i] = CMD_LOAD;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      F_INS_AFTER: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          // cells past the match open a gap right behind it
          for (int i = 0; i < CAPACITY; i++) begin
            if (!upto[i]) begin
              cmd[i] = (i > 0 && first[i - 1]) ? CMD_LOAD : CMD_LEFT;
            end
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      F_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i] = CMD_RIGHT;
          end
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      F_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      F_DEL_AFTER: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          // successor of the tail is the head: then the whole row closes up
          for (int i = 0; i < CAPACITY; i++) begin
            if (tail_hit || !upto[i]) cmd[i] = CMD_RIGHT;
          end
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      F_DUMP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          // emit the head and rotate the valid part of the row by one
          data_nxt = WORD_W'($signed(words[0]));
          last_nxt = (CW'(idx_r + 1'b1) == cnt_r);
          done     = last_nxt;
          for (int i = 0; i < CAPACITY; i++) begin
            if (tail[i])     cmd[i] = CMD_HEAD;
            else if (vld[i]) cmd[i] = CMD_RIGHT;
          end
        end
      end
      default: begin
        // unused selector: nothing changes
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] left_w, right_w;

    assign ctl.cmd    = step ? cmd[i] : CMD_HOLD;
    assign ctl.cmp_en = in_fire;

    if (i == 0) begin : g_first
      assign left_w = val_r;
    end else begin : g_mid_l
      assign left_w = words[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i + 1];
    end

    kcl_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_word  (val_r),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (words[0]),
      .key_word   (key_w),
      .word       (words[i]),
      .match      (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC, S_DUMP: begin
          if (step) begin
            state_r <= done ? S_IDLE : S_DUMP;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (in_fire) begin
        idx_r <= '0;
      end else if (step) begin
        idx_r <= idx_r + 1'b1;
      end

      if (step) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operation word and result payload need no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= func_t'(in_if.func);
      val_r  <= DATA_WIDTH'(in_if.data_in);
    end
    if (step) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      ecount_r <= ECOUNT_W'(cnt_nxt);
      last_r   <= last_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.data_out    = data_r;
  assign out_if.entry_count = ecount_r;
  assign out_if.last_out    = last_r;

endmodule

`default_nettype wire

// File: rtl/kcl_cell.sv
// one list position: stored word, neighbor mux and key compare
`default_nettype none

module kcl_cell import kcl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire cell_ctl_t             ctl,
  input  wire logic [DATA_WIDTH-1:0] load_word,
  input  wire logic [DATA_WIDTH-1:0] left_word,
  input  wire logic [DATA_WIDTH-1:0] right_word,
  input  wire logic [DATA_WIDTH-1:0] head_word,
  input  wire logic [DATA_WIDTH-1:0] key_word,
  output logic      [DATA_WIDTH-1:0] word,
  output logic                       match
);

  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic                  match_r;

  always_comb begin
    case (ctl.cmd)
      CMD_LOAD:  word_nxt = load_word;
      CMD_LEFT:  word_nxt = left_word;
      CMD_RIGHT: word_nxt = right_word;
      CMD_HEAD:  word_nxt = head_word;
      default:   word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (ctl.cmp_en) begin
      match_r <= (word_r == key_word);
    end
  end

  assign word  = word_r;
  assign match = match_r;

endmodule

`default_nettype wire

// File: rtl/kcl_checker.sv
// port-level checks of the list engine and their binding
`default_nettype none

module kcl_checker import kcl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kcl_in_if.sink     in_if,
  kcl_out_if.source  out_if
);

  // a stalled result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.status) &&
      $stable(out_if.data_out) && $stable(out_if.entry_count) &&
      $stable(out_if.last_out))
    else $error("result word changed while stalled");

  // one operation at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("accepted a word right after an accept");

  // no new operation while a dump is still running
  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.last_out |-> !in_if.ready)
    else $error("ready during a dump");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid after reset");

endmodule

bind keyed_circular_list_engine_core kcl_checker u_kcl_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);

`default_nettype wire
